[rtl/core/ascii_command_line_parser_top_defines.svh]
// ---------------------------------------------------------------------------
// ascii command line parser assertion macros
// concurrent assertion wrappers, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ASCII_COMMAND_LINE_PARSER_TOP_DEFINES_SVH
`define ASCII_COMMAND_LINE_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ACLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aclp assertion failed");
`define ACLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("aclp assertion failed");
`else
`define ACLP_ASSERT(lbl, prop)
`define ACLP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/aclp_pkg.sv]
// ---------------------------------------------------------------------------
// aclp_pkg
// types, codes and constants shared by the command line parser modules
// ---------------------------------------------------------------------------
package aclp_pkg;

  localparam int LINE_MAX        = 128;
  localparam int FRACTION_DIGITS = 4;
  localparam int CNT_W           = $clog2(LINE_MAX);
  localparam int FRAC_W          = 3;
  localparam int POW_W           = 20;
  localparam int PROD_W          = 24;
  localparam int SUM_W           = 36;
  localparam int FEAT_W          = 32;
  localparam int NUM_FEAT        = 4;
  localparam int FIELD_W         = 3;

  localparam logic [FEAT_W-1:0] SAT_MAG = 32'h7fff_ffff;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_V  = 8'h76;

  typedef enum logic [10:0] {
    PH_START        = 11'b000_0000_0001,
    PH_CMD_COMMA    = 11'b000_0000_0010,
    PH_LABEL_SIGN   = 11'b000_0000_0100,
    PH_LABEL_DIGITS = 11'b000_0000_1000,
    PH_LABEL_COMMA  = 11'b000_0001_0000,
    PH_NUM_START    = 11'b000_0010_0000,
    PH_NUM_INT      = 11'b000_0100_0000,
    PH_NUM_FRAC     = 11'b000_1000_0000,
    PH_FIELD_COMMA  = 11'b001_0000_0000,
    PH_TRAIL        = 11'b010_0000_0000,
    PH_DONE         = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [2:0] {
    CMD_HELP  = 3'd0,
    CMD_STATS = 3'd1,
    CMD_RESET = 3'd2,
    CMD_PRED  = 3'd3,
    CMD_VAL   = 3'd4,
    CMD_NONE  = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_FORMAT     = 4'd5,
    ERR_NUMBER     = 4'd6,
    ERR_COMMA      = 4'd7,
    ERR_EXTRA      = 4'd8,
    ERR_VFORMAT    = 4'd9,
    ERR_LABEL      = 4'd10,
    ERR_LABELCOMMA = 4'd11,
    ERR_UNKNOWN    = 4'd12
  } err_t;

  localparam logic [3:0] ST_PRED = 4'd3;
  localparam logic [3:0] ST_VAL  = 4'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
  } item_t;

  typedef struct packed {
    logic                           valid;
    logic [3:0]                     status;
    logic [NUM_FEAT-1:0][FEAT_W-1:0] features;
    logic [1:0]                     true_label;
  } result_t;

  function automatic logic [POW_W-1:0] pow_ten(input logic [FRAC_W-1:0] n);
    logic [POW_W-1:0] v;
    case (n)
      3'd0:    v = 20'd1;
      3'd1:    v = 20'd10;
      3'd2:    v = 20'd100;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd10000;
      3'd5:    v = 20'd100000;
      3'd6:    v = 20'd1000000;
      default: v = 20'd1;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/aclp_line.sv]
// ---------------------------------------------------------------------------
// aclp_line
// line assembly, per-character parse state and feature store
// ---------------------------------------------------------------------------
`include "ascii_command_line_parser_top_defines.svh"

module aclp_line (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  aclp_pkg::item_t  item,
  output aclp_pkg::result_t result
);
  import aclp_pkg::*;

  logic [CNT_W-1:0]   count;
  logic               ended;
  phase_t             phase;
  cmd_t               cmd;
  logic [FIELD_W-1:0] field;
  logic [FEAT_W-1:0]  acc;
  logic               neg;
  logic               seen;
  logic [FRAC_W-1:0]  frac;
  err_t               err;
  logic [1:0]         label;
  logic [NUM_FEAT-1:0][FEAT_W-1:0] store;

  logic [CNT_W-1:0]   count_next;
  logic               ended_next;
  phase_t             phase_next;
  cmd_t               cmd_next;
  logic [FIELD_W-1:0] field_next;
  logic [FEAT_W-1:0]  acc_next;
  logic               neg_next;
  logic               seen_next;
  logic [FRAC_W-1:0]  frac_next;
  err_t               err_next;
  logic [1:0]         label_next;

  // one character through the parser
  phase_t             f_phase;
  cmd_t               f_cmd;
  logic [FIELD_W-1:0] f_field;
  logic [FEAT_W-1:0]  f_acc;
  logic               f_neg;
  logic               f_seen;
  logic [FRAC_W-1:0]  f_frac;
  err_t               f_err;
  logic [1:0]         f_label;
  logic               store_we;
  logic [1:0]         store_idx;
  logic [FEAT_W-1:0]  store_data;
  logic               finish;
  logic               sep;
  phase_t             sep_phase;

  logic               is_term;
  logic [7:0]         ch;
  logic [7:0]         lower;
  logic               blank;
  logic               digit;
  logic [3:0]         dval;
  logic [POW_W-1:0]   scale;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   base;
  logic [SUM_W-1:0]   sum;
  logic [FEAT_W-1:0]  acc_sat;
  logic               fits;
  logic               line_clear;
  err_t               p_err;
  cmd_t               p_cmd;
  logic [1:0]         p_label;
  logic [3:0]         p_status;

  assign is_term = (item.rx_byte == CH_CR) || (item.rx_byte == CH_LF);
  assign ch      = is_term ? CH_NUL : item.rx_byte;
  assign lower   = ch | CH_CASE;
  assign blank   = (ch == CH_SPACE) || (ch == CH_TAB);
  assign digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval    = ch[3:0];
  assign fits    = count < CNT_W'(LINE_MAX - 1);

  // shared accumulate: label and integer digits scale by ten, fraction digits add
  always_comb begin
    if (phase == PH_NUM_FRAC) begin
      scale = pow_ten(FRAC_W'(FRACTION_DIGITS - 1) - frac);
      base  = SUM_W'(acc);
    end else if (phase == PH_LABEL_SIGN || phase == PH_LABEL_DIGITS) begin
      scale = POW_W'(1);
      base  = SUM_W'({acc, 3'b000}) + SUM_W'({acc, 1'b0});
    end else begin
      scale = pow_ten(FRAC_W'(FRACTION_DIGITS));
      base  = SUM_W'({acc, 3'b000}) + SUM_W'({acc, 1'b0});
    end
    prod    = PROD_W'(dval) * PROD_W'(scale);
    sum     = base + SUM_W'(prod);
    acc_sat = (sum > SUM_W'(SAT_MAG)) ? SAT_MAG : sum[FEAT_W-1:0];
  end

  always_comb begin
    f_phase    = phase;
    f_cmd      = cmd;
    f_field    = field;
    f_acc      = acc;
    f_neg      = neg;
    f_seen     = seen;
    f_frac     = frac;
    f_err      = err;
    f_label    = label;
    store_we   = 1'b0;
    store_idx  = field[1:0];
    store_data = neg ? (FEAT_W'(0) - acc) : acc;
    finish     = 1'b0;
    sep        = 1'b0;
    sep_phase  = phase;

    unique case (phase)
      PH_START: begin
        f_phase = PH_DONE;
        if (ch == CH_NUL) begin
          f_cmd = CMD_NONE;
        end else if (lower == CH_LO_H || ch == CH_QUERY) begin
          f_cmd = CMD_HELP;
        end else if (lower == CH_LO_S) begin
          f_cmd = CMD_STATS;
        end else if (lower == CH_LO_R) begin
          f_cmd = CMD_RESET;
        end else if (lower == CH_LO_P) begin
          f_cmd   = CMD_PRED;
          f_phase = PH_CMD_COMMA;
        end else if (lower == CH_LO_V) begin
          f_cmd   = CMD_VAL;
          f_phase = PH_CMD_COMMA;
        end else begin
          f_err = ERR_UNKNOWN;
        end
      end
      PH_CMD_COMMA: begin
        if (!blank) begin
          if (ch == CH_COMMA) begin
            f_acc   = '0;
            f_neg   = 1'b0;
            f_seen  = 1'b0;
            f_frac  = '0;
            f_phase = (cmd == CMD_VAL) ? PH_LABEL_SIGN : PH_NUM_START;
          end else begin
            f_err   = (cmd == CMD_VAL) ? ERR_VFORMAT : ERR_FORMAT;
            f_phase = PH_DONE;
          end
        end
      end
      PH_LABEL_SIGN: begin
        if (!blank) begin
          f_phase = PH_LABEL_DIGITS;
          if (ch == CH_MINUS) begin
            f_neg = 1'b1;
          end else if (ch == CH_PLUS) begin
            f_neg = neg;
          end else if (digit) begin
            f_acc  = acc_sat;
            f_seen = 1'b1;
          end else begin
            f_err   = ERR_VFORMAT;
            f_phase = PH_DONE;
          end
        end
      end
      PH_LABEL_DIGITS: begin
        if (digit) begin
          f_acc  = acc_sat;
          f_seen = 1'b1;
        end else if (!seen) begin
          f_err   = ERR_VFORMAT;
          f_phase = PH_DONE;
        end else if (acc > FEAT_W'(2) || (neg && acc != '0)) begin
          f_err   = ERR_LABEL;
          f_phase = PH_DONE;
        end else begin
          f_label   = acc[1:0];
          sep       = 1'b1;
          sep_phase = PH_LABEL_COMMA;
        end
      end
      PH_NUM_START: begin
        if (!blank) begin
          f_phase = PH_NUM_INT;
          if (ch == CH_MINUS) begin
            f_neg = 1'b1;
          end else if (ch == CH_PLUS) begin
            f_neg = neg;
          end else if (digit) begin
            f_acc  = acc_sat;
            f_seen = 1'b1;
          end else if (ch == CH_POINT) begin
            f_phase = PH_NUM_FRAC;
          end else begin
            f_err   = ERR_NUMBER;
            f_phase = PH_DONE;
          end
        end
      end
      PH_NUM_INT: begin
        if (digit) begin
          f_acc  = acc_sat;
          f_seen = 1'b1;
        end else if (ch == CH_POINT) begin
          f_phase = PH_NUM_FRAC;
        end else begin
          finish = 1'b1;
        end
      end
      PH_NUM_FRAC: begin
        if (digit) begin
          f_seen = 1'b1;
          if (frac < FRAC_W'(FRACTION_DIGITS)) begin
            f_frac = frac + FRAC_W'(1);
            f_acc  = acc_sat;
          end
        end else begin
          finish = 1'b1;
        end
      end
      PH_LABEL_COMMA, PH_FIELD_COMMA, PH_TRAIL: begin
        sep = 1'b1;
      end
      PH_DONE: begin
        f_phase = phase;
      end
      default: begin
        f_phase = phase;
      end
    endcase

    // end of a number hands the same character on to the separator
    if (finish) begin
      if (!seen) begin
        f_err   = ERR_NUMBER;
        f_phase = PH_DONE;
      end else begin
        store_we  = 1'b1;
        f_field   = field + FIELD_W'(1);
        sep       = 1'b1;
        sep_phase = (f_field < FIELD_W'(NUM_FEAT)) ? PH_FIELD_COMMA : PH_TRAIL;
      end
    end

    if (sep) begin
      if (blank) begin
        f_phase = sep_phase;
      end else if (sep_phase == PH_TRAIL) begin
        if (ch == CH_NUL) begin
          f_phase = PH_DONE;
        end else begin
          f_err   = ERR_EXTRA;
          f_phase = PH_DONE;
        end
      end else if (ch == CH_COMMA) begin
        f_acc   = '0;
        f_neg   = 1'b0;
        f_seen  = 1'b0;
        f_frac  = '0;
        f_phase = PH_NUM_START;
      end else begin
        f_err   = (sep_phase == PH_LABEL_COMMA) ? ERR_LABELCOMMA : ERR_COMMA;
        f_phase = PH_DONE;
      end
    end
  end

  // line control
  always_comb begin
    line_clear = 1'b0;
    count_next = count;
    ended_next = ended;
    phase_next = phase;
    cmd_next   = cmd;
    field_next = field;
    acc_next   = acc;
    neg_next   = neg;
    seen_next  = seen;
    frac_next  = frac;
    err_next   = err;
    label_next = label;
    if (step) begin
      if (item.rx_error) begin
        line_clear = 1'b1;
      end else if (is_term) begin
        line_clear = (count != '0);
      end else if (fits) begin
        count_next = count + CNT_W'(1);
        if (!ended) begin
          ended_next = (ch == CH_NUL);
          phase_next = f_phase;
          cmd_next   = f_cmd;
          field_next = f_field;
          acc_next   = f_acc;
          neg_next   = f_neg;
          seen_next  = f_seen;
          frac_next  = f_frac;
          err_next   = f_err;
          label_next = f_label;
        end
      end else begin
        line_clear = 1'b1;
      end
    end
    if (line_clear) begin
      count_next = '0;
      ended_next = 1'b0;
      phase_next = PH_START;
      cmd_next   = CMD_NONE;
      field_next = '0;
      acc_next   = '0;
      neg_next   = 1'b0;
      seen_next  = 1'b0;
      frac_next  = '0;
      err_next   = ERR_NONE;
      label_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ended <= 1'b0;
      phase <= PH_START;
      cmd   <= CMD_NONE;
      field <= '0;
      acc   <= '0;
      neg   <= 1'b0;
      seen  <= 1'b0;
      frac  <= '0;
      err   <= ERR_NONE;
      label <= '0;
    end else begin
      count <= count_next;
      ended <= ended_next;
      phase <= phase_next;
      cmd   <= cmd_next;
      field <= field_next;
      acc   <= acc_next;
      neg   <= neg_next;
      seen  <= seen_next;
      frac  <= frac_next;
      err   <= err_next;
      label <= label_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !item.rx_error && !ended && store_we) begin
      store[store_idx] <= store_data;
    end
  end

  // line end: state after the closing end-of-content character
  assign p_err    = ended ? err : f_err;
  assign p_cmd    = ended ? cmd : f_cmd;
  assign p_label  = ended ? label : f_label;
  assign p_status = (p_err != ERR_NONE) ? p_err : {1'b0, p_cmd};

  always_comb begin
    result.valid      = step && !item.rx_error && is_term && (count != '0) &&
                        (p_err != ERR_NONE || p_cmd != CMD_NONE);
    result.status     = p_status;
    result.true_label = (p_status == ST_VAL) ? p_label : 2'd0;
    for (int j = 0; j < NUM_FEAT; j++) begin
      if (p_status == ST_PRED || p_status == ST_VAL) begin
        result.features[j] = (!ended && store_we && store_idx == 2'(j)) ?
                             store_data : store[j];
      end else begin
        result.features[j] = '0;
      end
    end
  end

  `ACLP_ASSERT(a_field_range, field <= FIELD_W'(NUM_FEAT))
  `ACLP_ASSERT(a_trail_after_four, (phase == PH_TRAIL) |-> (field == FIELD_W'(NUM_FEAT)))
  `ACLP_ASSERT(a_term_clears, (step && !item.rx_error && is_term) |=> (count == '0 && phase == PH_START && err == ERR_NONE))

endmodule

[rtl/core/ascii_command_line_parser_top.sv]
// ---------------------------------------------------------------------------
// ascii_command_line_parser_top
// streaming parser for help, statistics, reset, predict and validate lines
// ---------------------------------------------------------------------------
// result path: a CR or LF byte enters the input register, and its result is then held in the result register
// throughput: one byte per cycle while no held result waits on res_stall, set by
//   the single parse pass between the input register and the result register
// rx_stall rises only while a held result waits on res_stall
// reset: synchronous rst returns the parser to line start with no result
//   pending; the feature store is not cleared
`include "ascii_command_line_parser_top_defines.svh"

module ascii_command_line_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  input  logic               rx_error,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [3:0]         status,
  output logic signed [31:0] feature_one,
  output logic signed [31:0] feature_two,
  output logic signed [31:0] feature_three,
  output logic signed [31:0] feature_four,
  output logic [1:0]         true_label
);
  import aclp_pkg::*;

  logic    held;
  item_t   item;
  logic    advance;
  logic    step;
  result_t result;

  assign advance  = !res_valid || !res_stall;
  assign step     = held && advance;
  assign rx_stall = held && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!rx_stall) begin
      held <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      item.rx_byte  <= rx_byte;
      item.rx_error <= rx_error;
    end
  end

  aclp_line u_line (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      status        <= result.status;
      feature_one   <= result.features[0];
      feature_two   <= result.features[1];
      feature_three <= result.features[2];
      feature_four  <= result.features[3];
      true_label    <= result.true_label;
    end
  end

  `ACLP_ASSERT(a_feat_zero, (res_valid && status != ST_PRED && status != ST_VAL) |-> (feature_one == 0 && feature_two == 0 && feature_three == 0 && feature_four == 0))
  `ACLP_ASSERT(a_label_zero, (res_valid && status != ST_VAL) |-> (true_label == 2'd0))
  `ACLP_ASSERT(a_stall_cause, rx_stall |-> (held && res_valid && res_stall))
  `ACLP_ASSERT_ALWAYS(a_reset_idle, rst |=> (!res_valid && !held))

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command line parser testbench
// streams directed and random text lines through the parser, predicts each
// reply from a model of the line grammar or from a typed status, checks each reply field by field,
// with random idling on the byte side and random stalls on the reply side
// ----------------------------------------------------------------------------
module testbench;
  import aclp_pkg::*;

  typedef enum {BY_MODEL, TYPED, NO_REPLY} row_check_t;

  typedef struct packed {
    logic [3:0]           status;
    logic [3:0][31:0]     feat;
    logic [1:0]           label;
  } answer_t;

  typedef struct {
    string      text;
    int         nul_at;
    int         err_at;
    logic [7:0] term;
    row_check_t mode;
    logic [3:0] status;
  } row_t;

  localparam int NONE_AT = -1;
  localparam longint unsigned UNIT = 10 ** FRACTION_DIGITS;

  logic               clk;
  logic               rst;
  logic               rx_valid;
  logic               rx_stall;
  logic [7:0]         rx_byte;
  logic               rx_error;
  logic               res_valid;
  logic               res_stall;
  logic [3:0]         status;
  logic signed [31:0] feature_one;
  logic signed [31:0] feature_two;
  logic signed [31:0] feature_three;
  logic signed [31:0] feature_four;
  logic [1:0]         true_label;

  // line model state
  int unsigned ln_count;
  phase_t      ln_phase;
  cmd_t        ln_cmd;
  logic [2:0]  ln_field;
  err_t        ln_err;
  logic [1:0]  ln_label;
  bit          ln_ended;
  logic [31:0] num_acc;
  bit          num_neg;
  bit          num_digit;
  int          num_frac;
  logic [31:0] feat_mem [NUM_FEAT];

  answer_t    replies_due [$];
  answer_t    due;
  logic [8:0] line_q [$];
  row_t       rows [$];
  row_check_t row_mode = BY_MODEL;
  bit         calm = 1'b0;
  bit         failed = 1'b0;
  int         bytes_sent = 0;
  int         answers_made = 0;
  int         stall_left = 0;

  ascii_command_line_parser_top DUT (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .rx_error      (rx_error),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .feature_one   (feature_one),
    .feature_two   (feature_two),
    .feature_three (feature_three),
    .feature_four  (feature_four),
    .true_label    (true_label)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] clamp_mag(input logic [63:0] v);
    if (v > 64'(SAT_MAG)) return SAT_MAG;
    return v[31:0];
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit is_letter(input logic [7:0] c, input logic [7:0] lo);
    return (c == lo) || (c == (lo & ~CH_CASE));
  endfunction

  function automatic void reject(input err_t code);
    ln_err   = code;
    ln_phase = PH_DONE;
  endfunction

  function automatic void begin_token(input phase_t ph);
    num_acc   = '0;
    num_neg   = 1'b0;
    num_digit = 1'b0;
    num_frac  = 0;
    ln_phase  = ph;
  endfunction

  function automatic void line_clear();
    ln_count = 0;
    ln_ended = 1'b0;
    ln_cmd   = CMD_NONE;
    ln_field = '0;
    ln_err   = ERR_NONE;
    ln_label = '0;
    begin_token(PH_START);
  endfunction

  function automatic void close_number();
    if (!num_digit) begin
      reject(ERR_NUMBER);
      return;
    end
    feat_mem[ln_field[1:0]] = num_neg ? (32'd0 - num_acc) : num_acc;
    ln_field = ln_field + 3'd1;
    if (ln_field < NUM_FEAT) ln_phase = PH_FIELD_COMMA;
    else ln_phase = PH_TRAIL;
  endfunction

  // returns 1 when the character is used up, 0 when it must be looked at again
  function automatic bit step_char(input logic [7:0] c);
    case (ln_phase)
      PH_START: begin
        ln_phase = PH_DONE;
        if (c == CH_NUL) ln_cmd = CMD_NONE;
        else if (is_letter(c, CH_LO_H) || c == CH_QUERY) ln_cmd = CMD_HELP;
        else if (is_letter(c, CH_LO_S)) ln_cmd = CMD_STATS;
        else if (is_letter(c, CH_LO_R)) ln_cmd = CMD_RESET;
        else if (is_letter(c, CH_LO_P)) begin
          ln_cmd   = CMD_PRED;
          ln_phase = PH_CMD_COMMA;
        end else if (is_letter(c, CH_LO_V)) begin
          ln_cmd   = CMD_VAL;
          ln_phase = PH_CMD_COMMA;
        end else reject(ERR_UNKNOWN);
        return 1'b1;
      end
      PH_CMD_COMMA: begin
        if (is_blank(c)) return 1'b1;
        if (c == CH_COMMA) begin
          if (ln_cmd == CMD_VAL) begin_token(PH_LABEL_SIGN);
          else begin_token(PH_NUM_START);
        end else if (ln_cmd == CMD_VAL) reject(ERR_VFORMAT);
        else reject(ERR_FORMAT);
        return 1'b1;
      end
      PH_LABEL_SIGN, PH_NUM_START: begin
        if (is_blank(c)) return 1'b1;
        if (ln_phase == PH_LABEL_SIGN) ln_phase = PH_LABEL_DIGITS;
        else ln_phase = PH_NUM_INT;
        if (c == CH_MINUS) begin
          num_neg = 1'b1;
          return 1'b1;
        end
        return c == CH_PLUS;
      end
      PH_LABEL_DIGITS: begin
        if (is_digit(c)) begin
          num_acc   = clamp_mag(64'(num_acc) * 10 + 64'(c - CH_ZERO));
          num_digit = 1'b1;
          return 1'b1;
        end
        if (!num_digit) begin
          reject(ERR_VFORMAT);
          return 1'b1;
        end
        if (num_acc > 2 || (num_neg && num_acc != 0)) begin
          reject(ERR_LABEL);
          return 1'b1;
        end
        ln_label = num_acc[1:0];
        ln_phase = PH_LABEL_COMMA;
        return 1'b0;
      end
      PH_LABEL_COMMA, PH_FIELD_COMMA: begin
        if (is_blank(c)) return 1'b1;
        if (c == CH_COMMA) begin_token(PH_NUM_START);
        else if (ln_phase == PH_LABEL_COMMA) reject(ERR_LABELCOMMA);
        else reject(ERR_COMMA);
        return 1'b1;
      end
      PH_NUM_INT: begin
        if (is_digit(c)) begin
          num_acc   = clamp_mag(64'(num_acc) * 10 + 64'(c - CH_ZERO) * UNIT);
          num_digit = 1'b1;
          return 1'b1;
        end
        if (c == CH_POINT) begin
          ln_phase = PH_NUM_FRAC;
          return 1'b1;
        end
        close_number();
        return 1'b0;
      end
      PH_NUM_FRAC: begin
        if (is_digit(c)) begin
          num_digit = 1'b1;
          if (num_frac < FRACTION_DIGITS) begin
            num_frac = num_frac + 1;
            num_acc  = clamp_mag(64'(num_acc) +
                                 64'(c - CH_ZERO) * (UNIT / (10 ** num_frac)));
          end
          return 1'b1;
        end
        close_number();
        return 1'b0;
      end
      PH_TRAIL: begin
        if (is_blank(c)) return 1'b1;
        if (c == CH_NUL) ln_phase = PH_DONE;
        else reject(ERR_EXTRA);
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (step_char(c)) return;
    end
  endfunction

  // advances the line model by one byte transfer, returns 1 with a reply due
  function automatic bit parse_byte(input logic [7:0] b, input bit e, output answer_t r);
    bit got;
    r = '0;
    if (e) begin
      line_clear();
      return 1'b0;
    end
    if (b == CH_CR || b == CH_LF) begin
      if (ln_count == 0) return 1'b0;
      if (!ln_ended) feed_char(CH_NUL);
      got = (ln_err != ERR_NONE) || (ln_cmd != CMD_NONE);
      if (ln_err != ERR_NONE) r.status = ln_err;
      else begin
        r.status = {1'b0, ln_cmd};
        if (ln_cmd == CMD_PRED || ln_cmd == CMD_VAL) begin
          for (int j = 0; j < NUM_FEAT; j++) r.feat[j] = feat_mem[j];
        end
        if (ln_cmd == CMD_VAL) r.label = ln_label;
      end
      line_clear();
      return got;
    end
    if (ln_count < LINE_MAX - 1) begin
      ln_count = ln_count + 1;
      if (!ln_ended) begin
        feed_char(b);
        if (b == CH_NUL) ln_ended = 1'b1;
      end
    end else line_clear();
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic row_t mk_row(input string text, input int nul_at, input int err_at,
                                  input logic [7:0] term, input row_check_t mode,
                                  input logic [3:0] st);
    row_t r;
    r.text   = text;
    r.nul_at = nul_at;
    r.err_at = err_at;
    r.term   = term;
    r.mode   = mode;
    r.status = st;
    return r;
  endfunction

  function automatic string rep(input string s, input int n);
    string t;
    t = "";
    repeat (n) t = {t, s};
    return t;
  endfunction

  function automatic void put(input logic [7:0] b);
    line_q.push_back({1'b0, b});
  endfunction

  function automatic void put_digit();
    put(8'(CH_ZERO + 8'($urandom_range(0, 9))));
  endfunction

  function automatic void put_printable();
    put(8'($urandom_range(32, 126)));
  endfunction

  function automatic logic [7:0] pick_case(input logic [7:0] lo);
    if ($urandom_range(0, 1) == 0) return lo;
    return lo & ~CH_CASE;
  endfunction

  function automatic void put_blanks();
    if ($urandom_range(0, 3) != 0) return;
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 1) == 0) put(CH_SPACE);
      else put(CH_TAB);
    end
  endfunction

  function automatic void put_decimal();
    int nint;
    int nfrac;
    case ($urandom_range(0, 5))
      0: put(CH_MINUS);
      1: put(CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) nint = $urandom_range(5, 13);
    else nint = $urandom_range(0, 3);
    repeat (nint) put_digit();
    nfrac = 0;
    if ($urandom_range(0, 2) == 0) begin
      put(CH_POINT);
      nfrac = $urandom_range(0, 7);
      repeat (nfrac) put_digit();
    end
    if (nint == 0 && nfrac == 0 && $urandom_range(0, 3) != 0) put_digit();
  endfunction

  function automatic void put_label();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) put(CH_MINUS);
    else if (r == 1) put(CH_PLUS);
    r = $urandom_range(0, 9);
    if (r < 7) put(8'(CH_ZERO + 8'($urandom_range(0, 2))));
    else if (r < 9) put(8'(CH_ZERO + 8'($urandom_range(3, 9))));
    else repeat ($urandom_range(2, 12)) put_digit();
  endfunction

  function automatic void compose_line();
    int kind;
    int pos;
    bit val;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 62) begin
      val = $urandom_range(0, 1);
      put(pick_case(val ? CH_LO_V : CH_LO_P));
      put_blanks();
      put(CH_COMMA);
      if (val) begin
        put_blanks();
        put_label();
        put_blanks();
        put(CH_COMMA);
      end
      for (int k = 0; k < NUM_FEAT; k++) begin
        put_blanks();
        put_decimal();
        if (k < NUM_FEAT - 1) begin
          put_blanks();
          put(CH_COMMA);
        end
      end
      put_blanks();
      if ($urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, line_q.size() - 1);
        case ($urandom_range(0, 4))
          0: line_q[pos] = {1'b0, 8'($urandom)};
          1: line_q.insert(pos, {1'b0, CH_NUL});
          2: line_q.delete(pos);
          3: line_q.insert(pos, {1'b1, 8'($urandom)});
          default: line_q.insert(pos, {1'b0, 8'($urandom_range(32, 126))});
        endcase
      end
    end else if (kind < 77) begin
      case ($urandom_range(0, 3))
        0: put(pick_case(CH_LO_H));
        1: put(pick_case(CH_LO_S));
        2: put(pick_case(CH_LO_R));
        default: put(CH_QUERY);
      endcase
      repeat ($urandom_range(0, 4)) put_printable();
    end else if (kind < 87) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom));
    end else if (kind < 92) begin
      if ($urandom_range(0, 1) == 0) put(CH_NUL);
      repeat ($urandom_range(0, 3)) put_printable();
    end else if (kind < 98) begin
      repeat ($urandom_range(0, 6)) put_printable();
      line_q.push_back({1'b1, 8'($urandom)});
      repeat ($urandom_range(0, 3)) put_printable();
    end else begin
      repeat (LINE_MAX - 1 + $urandom_range(0, 2)) put_printable();
    end
    put(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit e);
    int gap;
    answer_t ans;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      rx_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid = 1'b1;
    rx_byte  = b;
    rx_error = e;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    if (!e) bytes_sent++;
    if (parse_byte(b, e, ans) && row_mode == BY_MODEL) begin
      replies_due.push_back(ans);
      answers_made++;
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i][7:0], line_q[i][8]);
  endtask

  task automatic drain_replies();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      failed = 1'b1;
    end
  endfunction

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        res_stall = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (replies_due.size() == 0) begin
        $error("unexpected reply transfer, status %0d", status);
        failed = 1'b1;
      end else begin
        due = replies_due.pop_front();
        check_field("status", 32'(due.status), 32'(status));
        check_field("feature_one", due.feat[0], feature_one);
        check_field("feature_two", due.feat[1], feature_two);
        check_field("feature_three", due.feat[2], feature_three);
        check_field("feature_four", due.feat[3], feature_four);
        check_field("true_label", 32'(due.label), 32'(true_label));
      end
    end
  end

  initial begin
    answer_t typed;
    int base_bytes;
    int base_answers;
    bit paused;
    rst      = 1'b1;
    rx_valid = 1'b0;
    rx_byte  = '0;
    rx_error = 1'b0;
    paused   = 1'b0;
    for (int j = 0; j < NUM_FEAT; j++) feat_mem[j] = '0;
    line_clear();

    rows.push_back(mk_row("h", NONE_AT, NONE_AT, CH_CR, TYPED, 4'(CMD_HELP)));
    rows.push_back(mk_row("?", NONE_AT, NONE_AT, CH_LF, TYPED, 4'(CMD_HELP)));
    rows.push_back(mk_row("S", NONE_AT, NONE_AT, CH_CR, TYPED, 4'(CMD_STATS)));
    rows.push_back(mk_row("r,anything 9", NONE_AT, NONE_AT, CH_LF, TYPED, 4'(CMD_RESET)));
    rows.push_back(mk_row("Q", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_UNKNOWN));
    rows.push_back(mk_row(" h", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_UNKNOWN));
    rows.push_back(mk_row("p,1,2,3,4", NONE_AT, NONE_AT, CH_CR, BY_MODEL, ERR_NONE));
    rows.push_back(mk_row("P ,\t-0.5 , +12.34567,.5,7.", NONE_AT, NONE_AT, CH_LF,
                          BY_MODEL, ERR_NONE));
    rows.push_back(mk_row("p,99999999999,-214748.3648,-0,-0.0000", NONE_AT, NONE_AT,
                          CH_CR, BY_MODEL, ERR_NONE));
    rows.push_back(mk_row("v,2,1,-2,3.25,4", NONE_AT, NONE_AT, CH_CR, BY_MODEL, ERR_NONE));
    rows.push_back(mk_row("V\t, +0 , 0 ,0,0,0 \t ", NONE_AT, NONE_AT, CH_LF,
                          BY_MODEL, ERR_NONE));
    rows.push_back(mk_row("p1", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_FORMAT));
    rows.push_back(mk_row("p,1,,2,3", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_NUMBER));
    rows.push_back(mk_row("p,- 1,2,3,4", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_NUMBER));
    rows.push_back(mk_row("p,1 2", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_COMMA));
    rows.push_back(mk_row("p,1,2,3,4 x", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_EXTRA));
    rows.push_back(mk_row("v;", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_VFORMAT));
    rows.push_back(mk_row("v,,1", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_VFORMAT));
    rows.push_back(mk_row("v,3,1,2,3,4", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_LABEL));
    rows.push_back(mk_row("v,-1", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_LABEL));
    rows.push_back(mk_row("v,99999999999", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_LABEL));
    rows.push_back(mk_row("v,1 x", NONE_AT, NONE_AT, CH_CR, TYPED, ERR_LABELCOMMA));
    rows.push_back(mk_row("", NONE_AT, NONE_AT, CH_LF, NO_REPLY, ERR_NONE));
    rows.push_back(mk_row("hx", 0, NONE_AT, CH_CR, NO_REPLY, ERR_NONE));
    rows.push_back(mk_row("p,1,2,3,4zz", 9, NONE_AT, CH_CR, BY_MODEL, ERR_NONE));
    rows.push_back(mk_row("p,1zh", NONE_AT, 3, CH_CR, TYPED, ERR_UNKNOWN));
    rows.push_back(mk_row(rep("h", LINE_MAX - 1), NONE_AT, NONE_AT, CH_CR,
                          TYPED, 4'(CMD_HELP)));
    rows.push_back(mk_row({rep("s", LINE_MAX), "r"}, NONE_AT, NONE_AT, CH_LF,
                          TYPED, 4'(CMD_RESET)));
    rows.push_back(mk_row(rep("x", LINE_MAX), NONE_AT, NONE_AT, CH_CR, NO_REPLY, ERR_NONE));

    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      line_q.delete();
      for (int k = 0; k <= rows[i].text.len(); k++) begin
        if (k == rows[i].nul_at) put(CH_NUL);
        if (k == rows[i].err_at) line_q.push_back({1'b1, 8'($urandom)});
        if (k < rows[i].text.len()) put(rows[i].text[k]);
      end
      put(rows[i].term);
      row_mode = rows[i].mode;
      send_line();
      if (row_mode == TYPED) begin
        typed        = '0;
        typed.status = rows[i].status;
        replies_due.push_back(typed);
      end
    end
    row_mode = BY_MODEL;

    // hold off until every reply of the directed lines has come back
    @(negedge clk);
    rx_valid = 1'b0;
    drain_replies();

    base_bytes   = bytes_sent;
    base_answers = answers_made;
    while (bytes_sent - base_bytes < 700 || answers_made - base_answers < 48) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      compose_line();
      send_line();
      if (!paused && bytes_sent - base_bytes > 350) begin
        paused = 1'b1;
        drain_replies();
      end
    end

    @(negedge clk);
    rx_valid = 1'b0;
    drain_replies();
    repeat (8) @(posedge clk);
    if (failed) begin
      $display("[FAIL] regression broken");
    end else begin
      $display("[ OK ] regression clean");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/aclp_pkg.sv
rtl/core/aclp_line.sv
rtl/core/ascii_command_line_parser_top.sv
verif/testbench.sv
